// ===== rtl/pitct_pkg.sv =====
// ----------------------------------------------------------------------------
// Point in triangle test package
// Shared register indexes, tolerance widths and the stage enable bundle.
// ----------------------------------------------------------------------------
package pitct_pkg;

    localparam int CFG_INDEX_W  = 3;
    localparam int AREA_TOL_W   = 16;
    localparam int COORD_TOL_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_A_X     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_A_Y     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_B_X     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_B_Y     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_C_X     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_C_Y     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_AREA_TOLERANCE = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_COORD_TOLERANCE = 3'd7;

    localparam logic [AREA_TOL_W-1:0]  AREA_TOL_RESET  = 16'd1;
    localparam logic [COORD_TOL_W-1:0] COORD_TOL_RESET = 8'd1;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

// ===== rtl/point_in_triangle_cross_test_top.sv =====
// ----------------------------------------------------------------------------
// Point in triangle test, top level
// Edge function test of a stream of query points against a configured triangle.
// ----------------------------------------------------------------------------
// The block takes one query word per cycle whenever o_ready is high and returns
// one result word per query through the four register stages: coordinate
// differences, the signed multipliers, the cross product subtraction and the
// final tolerance compare that feeds the output register. Stalls are absorbed
// stage by stage, so empty stages fill while a finished result waits to be
// taken. The triangle and the tolerances must be written only while no query
// is in flight.
// ----------------------------------------------------------------------------
module point_in_triangle_cross_test_top #(
    parameter int COORD_WIDTH = 16,
    localparam int CfgDataW = (COORD_WIDTH > pitct_pkg::AREA_TOL_W) ?
                              COORD_WIDTH : pitct_pkg::AREA_TOL_W
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pitct_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [CfgDataW-1:0]                  i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [COORD_WIDTH-1:0]        i_point_x,
    input  logic signed [COORD_WIDTH-1:0]        i_point_y,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_inside_res,
    output logic                                 o_on_edge,
    output logic                                 o_degenerate
);

    localparam int CW = 2 * COORD_WIDTH + 3;
    localparam int BW = COORD_WIDTH + 2;
    localparam int DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] r_vx [3];
    logic signed [COORD_WIDTH-1:0] r_vy [3];
    logic [pitct_pkg::AREA_TOL_W-1:0]  r_area_tol;
    logic [pitct_pkg::COORD_TOL_W-1:0] r_coord_tol;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_out_valid;
    logic r_inside;
    logic r_on_edge;
    logic r_degen;

    logic signed [COORD_WIDTH-1:0] r_px;
    logic signed [COORD_WIDTH-1:0] r_py;
    logic [2:0] r_box2;
    logic [2:0] r_box3;
    logic       r_near2;
    logic       r_near3;

    logic en_out;
    logic en3;
    logic en2;
    logic en1;
    pitct_pkg::t_stage_en stage_en;

    logic [2:0] n_box;
    logic       n_near;
    logic signed [CW-1:0] edge_cr [3];
    logic signed [CW-1:0] area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
            r_area_tol  <= pitct_pkg::AREA_TOL_RESET;
            r_coord_tol <= pitct_pkg::COORD_TOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pitct_pkg::REG_VERTEX_A_X: r_vx[0] <= i_cfg_data[COORD_WIDTH-1:0];
                pitct_pkg::REG_VERTEX_A_Y: r_vy[0] <= i_cfg_data[COORD_WIDTH-1:0];
                pitct_pkg::REG_VERTEX_B_X: r_vx[1] <= i_cfg_data[COORD_WIDTH-1:0];
                pitct_pkg::REG_VERTEX_B_Y: r_vy[1] <= i_cfg_data[COORD_WIDTH-1:0];
                pitct_pkg::REG_VERTEX_C_X: r_vx[2] <= i_cfg_data[COORD_WIDTH-1:0];
                pitct_pkg::REG_VERTEX_C_Y: r_vy[2] <= i_cfg_data[COORD_WIDTH-1:0];
                pitct_pkg::REG_AREA_TOLERANCE:
                    r_area_tol <= i_cfg_data[pitct_pkg::AREA_TOL_W-1:0];
                pitct_pkg::REG_COORD_TOLERANCE:
                    r_coord_tol <= i_cfg_data[pitct_pkg::COORD_TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign en_out = !r_out_valid || i_ready;
    assign en3    = !r_v3 || en_out;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_ready = en1;

    always_comb begin
        stage_en.s1 = en1;
        stage_en.s2 = en2;
        stage_en.s3 = en3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en_out) begin
                r_out_valid <= r_v3;
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_edge
        pitct_cross #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cross (
            .i_clk   (i_clk),
            .i_en    (stage_en),
            .i_x1    (r_vx[k]),
            .i_y1    (r_vy[k]),
            .i_x2    (r_vx[(k + 1) % 3]),
            .i_y2    (r_vy[(k + 1) % 3]),
            .i_px    (i_point_x),
            .i_py    (i_point_y),
            .o_cross (edge_cr[k])
        );

        logic signed [COORD_WIDTH-1:0] lo_x;
        logic signed [COORD_WIDTH-1:0] hi_x;
        logic signed [COORD_WIDTH-1:0] lo_y;
        logic signed [COORD_WIDTH-1:0] hi_y;
        logic signed [BW-1:0]          tol_b;

        always_comb begin
            lo_x  = (r_vx[k] < r_vx[(k + 1) % 3]) ? r_vx[k] : r_vx[(k + 1) % 3];
            hi_x  = (r_vx[k] > r_vx[(k + 1) % 3]) ? r_vx[k] : r_vx[(k + 1) % 3];
            lo_y  = (r_vy[k] < r_vy[(k + 1) % 3]) ? r_vy[k] : r_vy[(k + 1) % 3];
            hi_y  = (r_vy[k] > r_vy[(k + 1) % 3]) ? r_vy[k] : r_vy[(k + 1) % 3];
            tol_b = BW'($signed({1'b0, r_coord_tol}));
            n_box[k] = (BW'(r_px) >= BW'(lo_x) - tol_b) &&
                       (BW'(r_px) <= BW'(hi_x) + tol_b) &&
                       (BW'(r_py) >= BW'(lo_y) - tol_b) &&
                       (BW'(r_py) <= BW'(hi_y) + tol_b);
        end
    end

    pitct_cross #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_area (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_x1    (r_vx[0]),
        .i_y1    (r_vy[0]),
        .i_x2    (r_vx[1]),
        .i_y2    (r_vy[1]),
        .i_px    (r_vx[2]),
        .i_py    (r_vy[2]),
        .o_cross (area)
    );

    logic signed [DW-1:0] diff_x;
    logic signed [DW-1:0] diff_y;
    logic [DW-1:0]        abs_x;
    logic [DW-1:0]        abs_y;

    always_comb begin
        diff_x = DW'(r_px) - DW'(r_vx[0]);
        diff_y = DW'(r_py) - DW'(r_vy[0]);
        abs_x  = (diff_x < 0) ? DW'(-diff_x) : DW'(diff_x);
        abs_y  = (diff_y < 0) ? DW'(-diff_y) : DW'(diff_y);
        n_near = (abs_x < DW'(r_coord_tol)) && (abs_y < DW'(r_coord_tol));
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        if (en2) begin
            r_box2  <= n_box;
            r_near2 <= n_near;
        end
        if (en3) begin
            r_box3  <= r_box2;
            r_near3 <= r_near2;
        end
    end

    logic signed [CW-1:0] atol_p;
    logic signed [CW-1:0] atol_n;
    logic signed [CW-1:0] lim_p;
    logic signed [CW-1:0] lim_n;
    logic [2:0] pos;
    logic [2:0] neg;
    logic       degen;
    logic       edge_hit;
    logic       n_inside;

    always_comb begin
        atol_p = CW'(r_area_tol);
        atol_n = -atol_p;
        lim_p  = atol_p <<< 1;
        lim_n  = -lim_p;
        for (int k = 0; k < 3; k++) begin
            pos[k] = edge_cr[k] > atol_p;
            neg[k] = edge_cr[k] < atol_n;
        end
        degen    = (area < lim_p) && (area > lim_n);
        edge_hit = |(~pos & ~neg & r_box3);
        n_inside = degen ? r_near3 : (edge_hit || (&pos) || (&neg));
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_inside  <= n_inside;
            r_on_edge <= !degen && edge_hit;
            r_degen   <= degen;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_on_edge    = r_on_edge;
    assign o_degenerate = r_degen;

`ifndef NO_ASSERTIONS
    a_degen_no_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> !o_on_edge)
        else $error("on_edge set for a degenerate triangle");

    a_edge_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_on_edge) |-> o_inside_res)
        else $error("point on an edge not reported inside");

    a_fill_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v1) |-> $past(i_valid && o_ready))
        else $error("first stage filled without an accepted word");
`endif

endmodule

// ===== rtl/pitct_cross.sv =====
// ----------------------------------------------------------------------------
// Edge cross product unit
// Three register stages: differences, the two products, then their difference.
// ----------------------------------------------------------------------------
module pitct_cross #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  pitct_pkg::t_stage_en              i_en,
    input  logic signed [COORD_WIDTH-1:0]     i_x1,
    input  logic signed [COORD_WIDTH-1:0]     i_y1,
    input  logic signed [COORD_WIDTH-1:0]     i_x2,
    input  logic signed [COORD_WIDTH-1:0]     i_y2,
    input  logic signed [COORD_WIDTH-1:0]     i_px,
    input  logic signed [COORD_WIDTH-1:0]     i_py,
    output logic signed [2*COORD_WIDTH+2:0]   o_cross
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int CW = 2 * COORD_WIDTH + 3;

    logic signed [DW-1:0] r_ex;
    logic signed [DW-1:0] r_ey;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic signed [CW-1:0] r_cross;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_ex <= DW'(i_x2) - DW'(i_x1);
            r_ey <= DW'(i_y2) - DW'(i_y1);
            r_dx <= DW'(i_px) - DW'(i_x1);
            r_dy <= DW'(i_py) - DW'(i_y1);
        end
        if (i_en.s2) begin
            r_p1 <= PW'(r_ex) * PW'(r_dy);
            r_p2 <= PW'(r_ey) * PW'(r_dx);
        end
        if (i_en.s3) begin
            r_cross <= CW'(r_p1) - CW'(r_p2);
        end
    end

    assign o_cross = r_cross;

endmodule

// ===== dv/point_in_triangle_cross_test_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point in triangle test, testbench
// Streams query points against a series of triangle and tolerance settings,
// predicts each result word from the edge functions and compares it field by
// field, with random bursts on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD        = 10;
    localparam int CW                = 16;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int RANDOM_PHASES     = 11;
    localparam int QUERIES_PER_PHASE = 50;

    class containment_scoreboard;
        typedef struct {
            logic is_inside;
            logic is_on_edge;
            logic is_degenerate;
        } t_flags;

        logic [15:0] regs [8];
        t_flags expected_flags [$];
        int errors;

        function new();
            errors = 0;
            foreach (regs[i]) regs[i] = '0;
            regs[pitct_pkg::REG_AREA_TOLERANCE] = pitct_pkg::AREA_TOL_RESET;
            regs[pitct_pkg::REG_COORD_TOLERANCE] = {8'd0, pitct_pkg::COORD_TOL_RESET};
        endfunction

        function void set_reg(logic [pitct_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
            regs[idx] = data;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        function longint edge_fn(longint x1, longint y1, longint x2, longint y2,
                                 longint x3, longint y3);
            return (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
        endfunction

        function bit near_segment(longint x1, longint y1, longint x2, longint y2,
                                  longint px, longint py, longint cr,
                                  longint atol, longint ctol);
            if (cr > atol || cr < -atol) begin
                return 1'b0;
            end
            return px >= ((x1 < x2) ? x1 : x2) - ctol && px <= ((x1 > x2) ? x1 : x2) + ctol &&
                   py >= ((y1 < y2) ? y1 : y2) - ctol && py <= ((y1 > y2) ? y1 : y2) + ctol;
        endfunction

        function void predict_containment(logic [15:0] px_word, logic [15:0] py_word);
            longint ax, ay, bx, by, cx, cy, px, py, atol, ctol;
            longint area, e1, e2, e3, dx, dy;
            t_flags f;
            ax = $signed(regs[pitct_pkg::REG_VERTEX_A_X]);
            ay = $signed(regs[pitct_pkg::REG_VERTEX_A_Y]);
            bx = $signed(regs[pitct_pkg::REG_VERTEX_B_X]);
            by = $signed(regs[pitct_pkg::REG_VERTEX_B_Y]);
            cx = $signed(regs[pitct_pkg::REG_VERTEX_C_X]);
            cy = $signed(regs[pitct_pkg::REG_VERTEX_C_Y]);
            px = $signed(px_word);
            py = $signed(py_word);
            atol = regs[pitct_pkg::REG_AREA_TOLERANCE];
            ctol = regs[pitct_pkg::REG_COORD_TOLERANCE][pitct_pkg::COORD_TOL_W-1:0];
            area = edge_fn(ax, ay, bx, by, cx, cy);
            f.is_degenerate = (area < 2 * atol) && (area > -2 * atol);
            f.is_on_edge = 1'b0;
            if (f.is_degenerate) begin
                dx = (px < ax) ? ax - px : px - ax;
                dy = (py < ay) ? ay - py : py - ay;
                f.is_inside = (dx < ctol) && (dy < ctol);
            end else begin
                e1 = edge_fn(ax, ay, bx, by, px, py);
                e2 = edge_fn(bx, by, cx, cy, px, py);
                e3 = edge_fn(cx, cy, ax, ay, px, py);
                f.is_on_edge = near_segment(ax, ay, bx, by, px, py, e1, atol, ctol) ||
                               near_segment(bx, by, cx, cy, px, py, e2, atol, ctol) ||
                               near_segment(cx, cy, ax, ay, px, py, e3, atol, ctol);
                f.is_inside = f.is_on_edge ||
                              (e1 > atol && e2 > atol && e3 > atol) ||
                              (e1 < -atol && e2 < -atol && e3 < -atol);
            end
            expected_flags.push_back(f);
        endfunction

        task check_result(logic got_inside, logic got_on_edge, logic got_degenerate);
            t_flags want;
            if (expected_flags.size() == 0) begin
                report("result word with no query outstanding");
                return;
            end
            want = expected_flags.pop_front();
            if (got_inside !== want.is_inside) begin
                report($sformatf("inside_res %b, expected %b", got_inside, want.is_inside));
            end
            if (got_on_edge !== want.is_on_edge) begin
                report($sformatf("on_edge %b, expected %b", got_on_edge, want.is_on_edge));
            end
            if (got_degenerate !== want.is_degenerate) begin
                report($sformatf("degenerate %b, expected %b",
                                 got_degenerate, want.is_degenerate));
            end
        endtask
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [pitct_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [15:0]                       i_cfg_data;
    logic                              i_valid;
    logic                              o_ready;
    logic signed [CW-1:0]              i_point_x;
    logic signed [CW-1:0]              i_point_y;
    logic                              o_valid;
    logic                              i_ready;
    logic                              o_inside_res;
    logic                              o_on_edge;
    logic                              o_degenerate;

    containment_scoreboard scoreboard;
    int tri_x [3];
    int tri_y [3];
    int cur_ctol;
    int idle_cycles = 0;

    point_in_triangle_cross_test_top #(
        .COORD_WIDTH(CW)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_inside_res (o_inside_res),
        .o_on_edge    (o_on_edge),
        .o_degenerate (o_degenerate)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            scoreboard.check_result(o_inside_res, o_on_edge, o_degenerate);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver changes its stall pattern after each run of random length.
    initial begin
        int mode, len, period, stall_len;
        i_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(32, 200);
            period = $urandom_range(4, 24);
            stall_len = $urandom_range(1, period - 1);
            for (int n = 0; n < len; n++) begin
                @(negedge i_clk);
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ((n % period) >= stall_len);
                endcase
            end
        end
    end

    function int span_pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task send_point(int px, int py);
        i_valid <= 1'b1;
        i_point_x <= CW'(px);
        i_point_y <= CW'(py);
        do @(posedge i_clk); while (o_ready !== 1'b1);
        scoreboard.predict_containment(CW'(px), CW'(py));
        @(negedge i_clk);
    endtask

    task pause(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task settle();
        i_valid <= 1'b0;
        while (scoreboard.expected_flags.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Registers are written back to back; the block must be idle.
    task load_triangle(int ax, int ay, int bx, int by, int cx, int cy,
                       logic [15:0] atol, logic [15:0] ctol_word);
        logic [15:0] words [8];
        words[pitct_pkg::REG_VERTEX_A_X] = 16'(ax);
        words[pitct_pkg::REG_VERTEX_A_Y] = 16'(ay);
        words[pitct_pkg::REG_VERTEX_B_X] = 16'(bx);
        words[pitct_pkg::REG_VERTEX_B_Y] = 16'(by);
        words[pitct_pkg::REG_VERTEX_C_X] = 16'(cx);
        words[pitct_pkg::REG_VERTEX_C_Y] = 16'(cy);
        words[pitct_pkg::REG_AREA_TOLERANCE] = atol;
        words[pitct_pkg::REG_COORD_TOLERANCE] = ctol_word;
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= pitct_pkg::CFG_INDEX_W'(i);
            i_cfg_data <= words[i];
            @(posedge i_clk);
            scoreboard.set_reg(pitct_pkg::CFG_INDEX_W'(i), words[i]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        tri_x[0] = $signed(words[pitct_pkg::REG_VERTEX_A_X]);
        tri_y[0] = $signed(words[pitct_pkg::REG_VERTEX_A_Y]);
        tri_x[1] = $signed(words[pitct_pkg::REG_VERTEX_B_X]);
        tri_y[1] = $signed(words[pitct_pkg::REG_VERTEX_B_Y]);
        tri_x[2] = $signed(words[pitct_pkg::REG_VERTEX_C_X]);
        tri_y[2] = $signed(words[pitct_pkg::REG_VERTEX_C_Y]);
        cur_ctol = ctol_word[pitct_pkg::COORD_TOL_W-1:0];
    endtask

    task pick_triangle();
        int kind, cx0, cy0, sp, dx, dy, k1, k2;
        int vx [3];
        int vy [3];
        logic [15:0] atol;
        logic [7:0] ctol;
        kind = $urandom_range(0, 5);
        case (kind)
            0, 1: begin
                cx0 = span_pick(-4000, 4000);
                cy0 = span_pick(-4000, 4000);
                sp = 1 << $urandom_range(3, 10);
                for (int t = 0; t < 3; t++) begin
                    vx[t] = cx0 + span_pick(-sp, sp);
                    vy[t] = cy0 + span_pick(-sp, sp);
                    if ($urandom_range(0, 1) == 1) begin
                        vx[t] = vx[t] & ~7;
                        vy[t] = vy[t] & ~7;
                    end
                end
            end
            2: begin
                for (int t = 0; t < 3; t++) begin
                    vx[t] = span_pick(-32768, 32767);
                    vy[t] = span_pick(-32768, 32767);
                end
            end
            3: begin
                cx0 = span_pick(-2000, 2000);
                cy0 = span_pick(-2000, 2000);
                dx = span_pick(-64, 64);
                dy = span_pick(-64, 64);
                k1 = span_pick(-20, 20);
                k2 = span_pick(-20, 20);
                vx = '{cx0, cx0 + dx * k1, cx0 + dx * k2};
                vy = '{cy0, cy0 + dy * k1, cy0 + dy * k2};
            end
            4: begin
                vx[0] = span_pick(-30000, 30000);
                vy[0] = span_pick(-30000, 30000);
                vx[1] = vx[0];
                vy[1] = vy[0];
                vx[2] = span_pick(-32768, 32767);
                vy[2] = span_pick(-32768, 32767);
            end
            default: begin
                for (int t = 0; t < 3; t++) begin
                    case ($urandom_range(0, 2))
                        0: vx[t] = -32768;
                        1: vx[t] = 32767;
                        default: vx[t] = 0;
                    endcase
                    case ($urandom_range(0, 2))
                        0: vy[t] = -32768;
                        1: vy[t] = 32767;
                        default: vy[t] = 0;
                    endcase
                end
            end
        endcase
        case ($urandom_range(0, 3))
            0: atol = '0;
            1: atol = '1;
            2: atol = 16'($urandom_range(0, 64));
            default: atol = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: ctol = '0;
            1: ctol = '1;
            2: ctol = 8'($urandom_range(0, 8));
            default: ctol = 8'($urandom);
        endcase
        load_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], atol,
                      {8'($urandom), ctol});
    endtask

    task pick_point(output int px, output int py);
        int minx, maxx, miny, maxy, i, j, k;
        minx = tri_x[0];
        maxx = tri_x[0];
        miny = tri_y[0];
        maxy = tri_y[0];
        for (int t = 1; t < 3; t++) begin
            minx = (tri_x[t] < minx) ? tri_x[t] : minx;
            maxx = (tri_x[t] > maxx) ? tri_x[t] : maxx;
            miny = (tri_y[t] < miny) ? tri_y[t] : miny;
            maxy = (tri_y[t] > maxy) ? tri_y[t] : maxy;
        end
        i = $urandom_range(0, 2);
        j = (i + 1) % 3;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                px = span_pick(minx - 16, maxx + 16);
                py = span_pick(miny - 16, maxy + 16);
            end
            4, 5: begin
                k = $urandom_range(0, 8);
                px = tri_x[i] + (tri_x[j] - tri_x[i]) * k / 8;
                py = tri_y[i] + (tri_y[j] - tri_y[i]) * k / 8;
                if ($urandom_range(0, 3) == 0) begin
                    px = px + span_pick(-1, 1);
                    py = py + span_pick(-1, 1);
                end
            end
            6: begin
                px = tri_x[0] + span_pick(-(cur_ctol + 1), cur_ctol + 1);
                py = tri_y[0] + span_pick(-(cur_ctol + 1), cur_ctol + 1);
            end
            7: begin
                px = tri_x[i];
                py = tri_y[i];
            end
            8: begin
                px = int'($urandom);
                py = int'($urandom);
            end
            default: begin
                px = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
                py = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            end
        endcase
    endtask

    task run_phase();
        int burst, drain_at, px, py;
        bit steady;
        settle();
        pick_triangle();
        steady = ($urandom_range(0, 3) == 0);
        drain_at = $urandom_range(5, QUERIES_PER_PHASE - 5);
        burst = $urandom_range(1, 24);
        for (int n = 0; n < QUERIES_PER_PHASE; n++) begin
            if (n == drain_at) begin
                settle();
            end else if (!steady && burst == 0) begin
                pause($urandom_range(1, 12));
                burst = $urandom_range(1, 24);
            end
            pick_point(px, py);
            send_point(px, py);
            if (burst > 0) begin
                burst = burst - 1;
            end
        end
    endtask

    initial begin
        scoreboard = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_point_x = '0;
        i_point_y = '0;
        tri_x = '{0, 0, 0};
        tri_y = '{0, 0, 0};
        cur_ctol = pitct_pkg::COORD_TOL_RESET;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // After reset the triangle collapses onto the origin.
        send_point(0, 0);
        send_point(1, 0);
        send_point(32767, -32768);
        settle();

        load_triangle(0, 0, 160, 0, 0, 160, 16'd1, 16'hAB01);
        send_point(16, 16);
        send_point(200, 200);
        send_point(80, 0);
        send_point(0, 0);
        send_point(320, 0);
        send_point(-1, 80);
        send_point(80, 80);
        send_point(-32768, -32768);
        send_point(32767, 32767);
        settle();

        // Clockwise winding, zero tolerances.
        load_triangle(0, 0, 0, 160, 160, 0, 16'd0, 16'h5500);
        send_point(16, 16);
        send_point(80, 0);
        send_point(-1, 80);
        send_point(0, 0);
        settle();

        load_triangle(-32768, -32768, 32767, -32768, -32768, 32767, 16'hFFFF, 16'h00FF);
        send_point(0, 0);
        send_point(32767, 32767);
        send_point(-32768, -32768);
        send_point(-32768, 0);
        settle();

        // Collinear vertices: only points close to vertex A are accepted.
        load_triangle(100, 100, 200, 200, 300, 300, 16'd5, 16'h00FF);
        send_point(100, 100);
        send_point(354, 100);
        send_point(355, 100);
        send_point(150, 150);
        settle();

        load_triangle(100, 100, 200, 200, 300, 300, 16'd5, 16'h3C00);
        send_point(100, 100);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            run_phase();
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.expected_flags.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pitct_pkg.sv
rtl/pitct_cross.sv
rtl/point_in_triangle_cross_test_top.sv
dv/point_in_triangle_cross_test_tb.sv
